// ----- rtl/core/okcm_pkg.sv -----
package okcm_pkg;

  localparam int AlphabetDef   = 27;
  localparam int ContextLenDef = 2;
  localparam int CountBitsDef  = 16;

  localparam int SymW      = 5;
  localparam int TotalBits = 24;
  localparam int CostW     = 22;
  localparam int DistW     = 48;
  localparam int SymsW     = 32;
  localparam int AlphaW    = 16;
  localparam int LogW      = 22;
  localparam int FracW     = 16;
  localparam int FracIdxW  = 10;
  localparam int CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] CfgMode  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgAlpha = 1'b1;

  localparam logic [AlphaW-1:0] AlphaReset = 16'd256;
  localparam logic [CostW-1:0]  CostMax    = {CostW{1'b1}};
  localparam logic [DistW-1:0]  DistMax    = {DistW{1'b1}};
  localparam logic [SymsW-1:0]  SymsMax    = {SymsW{1'b1}};

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            start_text;
  } in_t;

  typedef struct packed {
    logic             scored;
    logic [CostW-1:0] cost_q16;
    logic [DistW-1:0] distance_q16;
    logic [SymsW-1:0] symbol_total;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CALC,
    S_LOG,
    S_DONE
  } state_e;

  typedef logic [FracW-1:0] frac_tab_t [1024];

  function automatic frac_tab_t build_frac_tab();
    frac_tab_t   t;
    logic [63:0] x;
    logic [15:0] f;
    for (int i = 0; i < 1024; i++) begin
      x = 64'(1024 + i) << 20;
      f = '0;
      for (int b = 0; b < 16; b++) begin
        x = (x * x) >> 30;
        f = {f[14:0], 1'b0};
        if (x >= 64'h8000_0000) begin
          x    = x >> 1;
          f[0] = 1'b1;
        end
      end
      t[i] = f;
    end
    return t;
  endfunction

  localparam frac_tab_t FracTab = build_frac_tab();

endpackage

// ----- rtl/core/okcm_log2.sv -----
module okcm_log2 #(
  parameter int W = 25
) (
  input  logic                       clk_i,
  input  logic [W-1:0]               value_i,
  output logic [okcm_pkg::LogW-1:0]  log_o
);

  localparam int PosW = $clog2(W);

  logic [PosW-1:0] pos_c;
  logic [PosW-1:0] pos_q;
  logic [W-1:0]    val_q;
  logic [W+okcm_pkg::FracIdxW-1:0] shifted_c;
  logic [okcm_pkg::FracIdxW-1:0]   idx_c;
  logic [okcm_pkg::LogW-1:0]       log_q;

  // leading one position
  always_comb begin
    pos_c = '0;
    for (int i = 0; i < W; i++) begin
      if (value_i[i]) pos_c = PosW'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_c;
    val_q <= value_i;
  end

  // ten bits under the leading one, zero-filled when short
  assign shifted_c = {val_q, {okcm_pkg::FracIdxW{1'b0}}} >> pos_q;
  assign idx_c     = shifted_c[okcm_pkg::FracIdxW-1:0];

  always_ff @(posedge clk_i) begin
    log_q <= {(okcm_pkg::LogW - okcm_pkg::FracW)'(pos_q), okcm_pkg::FracTab[idx_c]};
  end

  assign log_o = log_q;

endmodule

// ----- rtl/core/order_k_context_model_cost_top.sv -----
// channel  | valid       | stall        | payload
// input    | in_valid_i  | in_stall_o   | in_data_i  (okcm_pkg::in_t)
// output   | out_valid_o | out_stall_i  | out_data_o (okcm_pkg::out_t)
// config   | cfg_we_i    | -            | cfg_idx_i, cfg_data_i
//
// a symbol visits IDLE and DONE while the context fills, plus READ and CALC in train
// mode and LOG too in score mode, set by the registered memory read and the two-stage log2 units
// after reset a clearing pass walks both memories, all ALPHABET**(CONTEXT_LEN+1) count cells
// (19683 at default) and the totals, during which no transaction is accepted
// a new input transaction is accepted while a finished result waits in the output
// register; the block only holds in its final state while that register is full and stalled
module order_k_context_model_cost_top #(
  parameter int ALPHABET    = okcm_pkg::AlphabetDef,
  parameter int CONTEXT_LEN = okcm_pkg::ContextLenDef,
  parameter int COUNT_BITS  = okcm_pkg::CountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  okcm_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output okcm_pkg::out_t               out_data_o,
  input  logic                         cfg_we_i,
  input  logic [okcm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [okcm_pkg::AlphaW-1:0]  cfg_data_i
);

  localparam int CtxSize = ALPHABET ** CONTEXT_LEN;
  localparam int CntSize = CtxSize * ALPHABET;
  localparam int CtxAw   = $clog2(CtxSize);
  localparam int CntAw   = $clog2(CntSize);
  localparam int FillW   = $clog2(CONTEXT_LEN + 1);
  localparam int NumW    = COUNT_BITS + 9;
  localparam int DenW    = okcm_pkg::TotalBits + 9;
  localparam int SymW    = okcm_pkg::SymW;

  localparam logic [COUNT_BITS-1:0]          CountMax = {COUNT_BITS{1'b1}};
  localparam logic [okcm_pkg::TotalBits-1:0] TotalMax = {okcm_pkg::TotalBits{1'b1}};

  okcm_pkg::state_e state_q, state_d;

  logic                        mode_q;
  logic [okcm_pkg::AlphaW-1:0] alpha_q;
  logic [SymW-1:0]             hist_q [CONTEXT_LEN];
  logic [FillW-1:0]            fill_q;
  logic [CntAw-1:0]            clr_q;
  logic [CntAw-1:0]            cell_q;
  logic [CtxAw-1:0]            ctx_q;
  logic                        score_q;
  logic [okcm_pkg::DistW-1:0]  dist_q;
  logic [okcm_pkg::SymsW-1:0]  syms_q;
  logic                        out_valid_q;
  okcm_pkg::out_t              out_q;

  // count and total memories
  logic [COUNT_BITS-1:0]          cnt_mem [CntSize];
  logic [okcm_pkg::TotalBits-1:0] tot_mem [CtxSize];
  logic [COUNT_BITS-1:0]          cnt_rd_q;
  logic [okcm_pkg::TotalBits-1:0] tot_rd_q;

  logic                           cnt_we, tot_we;
  logic [CntAw-1:0]               cnt_wa;
  logic [CtxAw-1:0]               tot_wa;
  logic [COUNT_BITS-1:0]          cnt_wd;
  logic [okcm_pkg::TotalBits-1:0] tot_wd;

  logic                  in_acc;
  logic                  out_free;
  logic [SymW-1:0]       sym_c;
  logic [CtxAw-1:0]      ctx_c;
  logic [CntAw-1:0]      cell_c;
  logic [FillW-1:0]      fill_eff;
  logic                  clr_last;

  logic [NumW-1:0]               num_c;
  logic [DenW-1:0]               den_c;
  logic [okcm_pkg::LogW-1:0]     log_num, log_den;
  logic [okcm_pkg::CostW-1:0]    cost_c;
  logic [okcm_pkg::DistW:0]      dist_sum;
  logic [okcm_pkg::DistW-1:0]    dist_next;
  logic [okcm_pkg::SymsW-1:0]    syms_next;

  assign in_stall_o = (state_q != okcm_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign clr_last   = (clr_q == CntAw'(CntSize - 1));

  // out-of-range symbols fold onto the last one
  assign sym_c = ({1'b0, in_data_i.symbol} >= (SymW + 1)'(ALPHABET)) ?
                 SymW'(ALPHABET - 1) : in_data_i.symbol;

  // context index, newest symbol least significant
  always_comb begin
    ctx_c = '0;
    for (int i = CONTEXT_LEN - 1; i >= 0; i--) begin
      ctx_c = CtxAw'(ctx_c * CtxAw'(ALPHABET)) + CtxAw'(hist_q[i]);
    end
  end

  assign cell_c   = CntAw'(CntAw'(ctx_c) * CntAw'(ALPHABET)) + CntAw'(sym_c);
  assign fill_eff = in_data_i.start_text ? '0 : fill_q;

  // memory write port: clearing pass or train-mode update
  always_comb begin
    cnt_we = 1'b0;
    tot_we = 1'b0;
    cnt_wa = cell_q;
    tot_wa = ctx_q;
    cnt_wd = (cnt_rd_q < CountMax) ? cnt_rd_q + 1'b1 : cnt_rd_q;
    tot_wd = (tot_rd_q < TotalMax) ? tot_rd_q + 1'b1 : tot_rd_q;
    if (state_q == okcm_pkg::S_CLEAR) begin
      cnt_we = 1'b1;
      tot_we = (clr_q < CntAw'(CtxSize));
      cnt_wa = clr_q;
      tot_wa = clr_q[CtxAw-1:0];
      cnt_wd = '0;
      tot_wd = '0;
    end else if (state_q == okcm_pkg::S_CALC && !mode_q) begin
      cnt_we = 1'b1;
      tot_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd_q <= cnt_mem[cell_q];
  end

  always_ff @(posedge clk_i) begin
    if (tot_we) tot_mem[tot_wa] <= tot_wd;
    tot_rd_q <= tot_mem[ctx_q];
  end

  // smoothed numerator and denominator in Q8
  assign num_c = {cnt_rd_q, 8'd0} + NumW'(alpha_q);
  assign den_c = {tot_rd_q, 8'd0} + DenW'(alpha_q * DenW'(ALPHABET));

  okcm_log2 #(.W(NumW)) u_log_num (
    .clk_i   (clk_i),
    .value_i (num_c),
    .log_o   (log_num)
  );

  okcm_log2 #(.W(DenW)) u_log_den (
    .clk_i   (clk_i),
    .value_i (den_c),
    .log_o   (log_den)
  );

  always_comb begin
    if (!score_q || !mode_q) begin
      cost_c = '0;
    end else if (num_c == '0) begin
      cost_c = okcm_pkg::CostMax;
    end else if (log_den > log_num) begin
      cost_c = okcm_pkg::CostW'(log_den - log_num);
    end else begin
      cost_c = '0;
    end
  end

  assign dist_sum  = {1'b0, dist_q} + (okcm_pkg::DistW + 1)'(cost_c);
  assign dist_next = dist_sum[okcm_pkg::DistW] ? okcm_pkg::DistMax
                                               : dist_sum[okcm_pkg::DistW-1:0];
  assign syms_next = (score_q && syms_q != okcm_pkg::SymsMax) ? syms_q + 1'b1 : syms_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      okcm_pkg::S_CLEAR: if (clr_last) state_d = okcm_pkg::S_IDLE;
      okcm_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (fill_eff == FillW'(CONTEXT_LEN)) ? okcm_pkg::S_READ
                                                      : okcm_pkg::S_DONE;
        end
      end
      okcm_pkg::S_READ: state_d = okcm_pkg::S_CALC;
      okcm_pkg::S_CALC: state_d = mode_q ? okcm_pkg::S_LOG : okcm_pkg::S_DONE;
      okcm_pkg::S_LOG:  state_d = okcm_pkg::S_DONE;
      okcm_pkg::S_DONE: if (out_free) state_d = okcm_pkg::S_IDLE;
      default:          state_d = okcm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= okcm_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      alpha_q <= okcm_pkg::AlphaReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        okcm_pkg::CfgMode:  mode_q  <= cfg_data_i[0];
        okcm_pkg::CfgAlpha: alpha_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // context, fill and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CONTEXT_LEN; i++) hist_q[i] <= '0;
      fill_q  <= '0;
      clr_q   <= '0;
      score_q <= 1'b0;
      dist_q  <= '0;
      syms_q  <= '0;
    end else begin
      if (state_q == okcm_pkg::S_CLEAR && !clr_last) clr_q <= clr_q + 1'b1;
      if (in_acc) begin
        for (int i = CONTEXT_LEN - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
        hist_q[0] <= sym_c;
        score_q   <= (fill_eff == FillW'(CONTEXT_LEN));
        if (fill_eff != FillW'(CONTEXT_LEN)) fill_q <= fill_eff + 1'b1;
        else                                 fill_q <= fill_eff;
        if (in_data_i.start_text) begin
          dist_q <= '0;
          syms_q <= '0;
        end
      end
      if (state_q == okcm_pkg::S_DONE && out_free) begin
        dist_q <= dist_next;
        syms_q <= syms_next;
      end
    end
  end

  // address registers for the memory reads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cell_q <= cell_c;
      ctx_q  <= ctx_c;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == okcm_pkg::S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == okcm_pkg::S_DONE && out_free) begin
      out_q.scored       <= score_q;
      out_q.cost_q16     <= cost_c;
      out_q.distance_q16 <= dist_next;
      out_q.symbol_total <= syms_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // no result and no acceptance while the memories are being cleared
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == okcm_pkg::S_CLEAR |-> !out_valid_q && in_stall_o)
    else $error("result or acceptance during clearing pass");

  // a nonzero cost only comes from a scored symbol
  a_cost_scored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.cost_q16 != '0 |-> out_data_o.scored)
    else $error("cost on an unscored symbol");

  // fill count never passes the context length
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(CONTEXT_LEN))
    else $error("fill count overrun");

  // an accepted filling symbol finishes without a memory access
  a_fill_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && fill_eff != FillW'(CONTEXT_LEN) |=> state_q == okcm_pkg::S_DONE && !score_q)
    else $error("filling symbol took the memory path");

endmodule
